// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ECR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ECR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg
// Types, constants and helpers for the 2D elastic collision pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecr_pkg;

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic signed [31:0] first_vel_x;
    logic signed [31:0] first_vel_y;
    logic        [31:0] first_mass;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic signed [31:0] second_vel_x;
    logic signed [31:0] second_vel_y;
    logic        [31:0] second_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_new_vel_x;
    logic signed [31:0] first_new_vel_y;
    logic signed [31:0] second_new_vel_x;
    logic signed [31:0] second_new_vel_y;
    logic               coincident;
  } out_item_t;

  // Values that ride alongside the arithmetic.
  typedef struct packed {
    logic signed [31:0] v1x;
    logic signed [31:0] v1y;
    logic signed [31:0] v2x;
    logic signed [31:0] v2y;
    logic               coinc;
    logic               sum0;
    logic               spx;
    logic               spy;
  } sb_t;

  // Mass weight division operands.
  typedef struct packed {
    logic [63:0] dvd;
    logic [32:0] den;
  } wt_t;

  localparam int DIV_DW    = 64;  // dividend width
  localparam int DIV_VW    = 33;  // divisor width
  localparam int DIV_QW    = 34;  // quotient bits, one per stage
  localparam int AXIS_BITS = 15;  // reduced axis magnitude width

  localparam logic [31:0] W_ONE = 32'h4000_0000;
  localparam logic [31:0] W_TWO = 32'h8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ecr_front.sv =====
// ----------------------------------------------------------------------------
// ecr_front
// Axis, reduction, dot product and projection dividends (nine stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_front (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire ecr_pkg::in_item_t in_item,
  output logic [63:0]           px_dvd,
  output logic [63:0]           py_dvd,
  output logic [30:0]           n_out,
  output ecr_pkg::wt_t          wt_out,
  output ecr_pkg::sb_t          sb_out
);

  // stage 1
  logic signed [32:0] ax1_r, ay1_r, dvx1_r, dvy1_r;
  logic        [32:0] sum1_r;
  logic        [31:0] m2_1_r;
  ecr_pkg::sb_t       sb1_r;
  // stage 2
  logic        [32:0] ux2_r, uy2_r;
  logic               nx2_r, ny2_r;
  logic signed [32:0] dvx2_r, dvy2_r;
  ecr_pkg::wt_t       wt2_r;
  ecr_pkg::sb_t       sb2_r;
  // stage 3
  logic        [4:0]  sh3_r;
  logic        [32:0] ux3_r, uy3_r;
  logic               nx3_r, ny3_r;
  logic signed [32:0] dvx3_r, dvy3_r;
  ecr_pkg::wt_t       wt3_r;
  ecr_pkg::sb_t       sb3_r;
  // stage 4
  logic [ecr_pkg::AXIS_BITS-1:0] ux4_r, uy4_r;
  logic signed [15:0] sax4_r, say4_r;
  logic               nx4_r, ny4_r;
  logic signed [32:0] dvx4_r, dvy4_r;
  ecr_pkg::wt_t       wt4_r;
  ecr_pkg::sb_t       sb4_r;
  // stage 5
  logic        [29:0] uxx5_r, uyy5_r;
  logic signed [48:0] pdx5_r, pdy5_r;
  logic [ecr_pkg::AXIS_BITS-1:0] ux5_r, uy5_r;
  logic               nx5_r, ny5_r;
  ecr_pkg::wt_t       wt5_r;
  ecr_pkg::sb_t       sb5_r;
  // stage 6
  logic        [30:0] n6_r;
  logic signed [49:0] dot6_r;
  logic [ecr_pkg::AXIS_BITS-1:0] ux6_r, uy6_r;
  logic               nx6_r, ny6_r;
  ecr_pkg::wt_t       wt6_r;
  ecr_pkg::sb_t       sb6_r;
  // stage 7
  logic        [48:0] udot7_r;
  logic        [30:0] n7_r;
  logic [ecr_pkg::AXIS_BITS-1:0] ux7_r, uy7_r;
  ecr_pkg::wt_t       wt7_r;
  ecr_pkg::sb_t       sb7_r;
  // stage 8
  logic        [63:0] prx8_r, pry8_r;
  logic        [30:0] n8_r;
  ecr_pkg::wt_t       wt8_r;
  ecr_pkg::sb_t       sb8_r;
  // stage 9
  logic        [63:0] pxd9_r, pyd9_r;
  logic        [30:0] n9_r;
  ecr_pkg::wt_t       wt9_r;
  ecr_pkg::sb_t       sb9_r;

  logic [32:0] or_mag;
  logic [5:0]  blen;
  logic [4:0]  sh_nxt;
  logic signed [49:0] ndot;
  ecr_pkg::sb_t sb2_nxt, sb7_nxt;

  // Shift count that brings both magnitudes under the axis limit.
  always_comb begin
    or_mag = ux2_r | uy2_r;
    blen   = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (or_mag[i]) begin
        blen = 6'(i + 1);
      end
    end
    if (blen > 6'(ecr_pkg::AXIS_BITS)) begin
      sh_nxt = 5'(blen - 6'(ecr_pkg::AXIS_BITS));
    end else begin
      sh_nxt = 5'd0;
    end
    ndot = -dot6_r;
    sb2_nxt      = sb1_r;
    sb2_nxt.sum0 = (sum1_r == 33'd0);
    sb7_nxt      = sb6_r;
    sb7_nxt.spx  = dot6_r[49] ^ nx6_r;
    sb7_nxt.spy  = dot6_r[49] ^ ny6_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: differences and mass sum
      ax1_r  <= 33'(in_item.second_pos_x) - 33'(in_item.first_pos_x);
      ay1_r  <= 33'(in_item.second_pos_y) - 33'(in_item.first_pos_y);
      dvx1_r <= 33'(in_item.second_vel_x) - 33'(in_item.first_vel_x);
      dvy1_r <= 33'(in_item.second_vel_y) - 33'(in_item.first_vel_y);
      sum1_r <= {1'b0, in_item.first_mass} + {1'b0, in_item.second_mass};
      m2_1_r <= in_item.second_mass;
      sb1_r.v1x   <= in_item.first_vel_x;
      sb1_r.v1y   <= in_item.first_vel_y;
      sb1_r.v2x   <= in_item.second_vel_x;
      sb1_r.v2y   <= in_item.second_vel_y;
      sb1_r.coinc <= (in_item.first_pos_x == in_item.second_pos_x) &&
                     (in_item.first_pos_y == in_item.second_pos_y);
      sb1_r.sum0  <= 1'b0;
      sb1_r.spx   <= 1'b0;
      sb1_r.spy   <= 1'b0;

      // stage 2: magnitudes, weight dividend
      ux2_r  <= ax1_r[32] ? 33'(-ax1_r) : 33'(ax1_r);
      uy2_r  <= ay1_r[32] ? 33'(-ay1_r) : 33'(ay1_r);
      nx2_r  <= ax1_r[32];
      ny2_r  <= ay1_r[32];
      dvx2_r <= dvx1_r;
      dvy2_r <= dvy1_r;
      wt2_r.dvd <= {1'b0, m2_1_r, 31'b0} + {32'b0, sum1_r[32:1]};
      wt2_r.den <= sum1_r;
      sb2_r      <= sb2_nxt;

      // stage 3: shift count
      sh3_r  <= sh_nxt;
      ux3_r  <= ux2_r;
      uy3_r  <= uy2_r;
      nx3_r  <= nx2_r;
      ny3_r  <= ny2_r;
      dvx3_r <= dvx2_r;
      dvy3_r <= dvy2_r;
      wt3_r  <= wt2_r;
      sb3_r  <= sb2_r;

      // stage 4: reduced axis
      ux4_r  <= ecr_pkg::AXIS_BITS'(ux3_r >> sh3_r);
      uy4_r  <= ecr_pkg::AXIS_BITS'(uy3_r >> sh3_r);
      sax4_r <= nx3_r ? -$signed({1'b0, ecr_pkg::AXIS_BITS'(ux3_r >> sh3_r)})
                      :  $signed({1'b0, ecr_pkg::AXIS_BITS'(ux3_r >> sh3_r)});
      say4_r <= ny3_r ? -$signed({1'b0, ecr_pkg::AXIS_BITS'(uy3_r >> sh3_r)})
                      :  $signed({1'b0, ecr_pkg::AXIS_BITS'(uy3_r >> sh3_r)});
      nx4_r  <= nx3_r;
      ny4_r  <= ny3_r;
      dvx4_r <= dvx3_r;
      dvy4_r <= dvy3_r;
      wt4_r  <= wt3_r;
      sb4_r  <= sb3_r;

      // stage 5: squares and dot terms
      uxx5_r <= 30'(ux4_r) * 30'(ux4_r);
      uyy5_r <= 30'(uy4_r) * 30'(uy4_r);
      pdx5_r <= 49'(sax4_r) * 49'(dvx4_r);
      pdy5_r <= 49'(say4_r) * 49'(dvy4_r);
      ux5_r  <= ux4_r;
      uy5_r  <= uy4_r;
      nx5_r  <= nx4_r;
      ny5_r  <= ny4_r;
      wt5_r  <= wt4_r;
      sb5_r  <= sb4_r;

      // stage 6: norm and dot
      n6_r   <= {1'b0, uxx5_r} + {1'b0, uyy5_r};
      dot6_r <= 50'(pdx5_r) + 50'(pdy5_r);
      ux6_r  <= ux5_r;
      uy6_r  <= uy5_r;
      nx6_r  <= nx5_r;
      ny6_r  <= ny5_r;
      wt6_r  <= wt5_r;
      sb6_r  <= sb5_r;

      // stage 7: dot magnitude and projection signs
      udot7_r   <= dot6_r[49] ? ndot[48:0] : dot6_r[48:0];
      n7_r      <= n6_r;
      ux7_r     <= ux6_r;
      uy7_r     <= uy6_r;
      wt7_r     <= wt6_r;
      sb7_r     <= sb7_nxt;

      // stage 8: scaled products
      prx8_r <= 64'(udot7_r) * 64'(ux7_r);
      pry8_r <= 64'(udot7_r) * 64'(uy7_r);
      n8_r   <= n7_r;
      wt8_r  <= wt7_r;
      sb8_r  <= sb7_r;

      // stage 9: add half divisor for rounding
      pxd9_r <= prx8_r + {34'b0, n8_r[30:1]};
      pyd9_r <= pry8_r + {34'b0, n8_r[30:1]};
      n9_r   <= n8_r;
      wt9_r  <= wt8_r;
      sb9_r  <= sb8_r;
    end
  end

  assign px_dvd = pxd9_r;
  assign py_dvd = pyd9_r;
  assign n_out  = n9_r;
  assign wt_out = wt9_r;
  assign sb_out = sb9_r;

endmodule

`default_nettype wire

// ===== src/ecr_div.sv =====
// ----------------------------------------------------------------------------
// ecr_div
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ecr_pkg::DIV_DW-1:0]    dvd,
  input  wire logic [ecr_pkg::DIV_VW-1:0]    den,
  output logic      [ecr_pkg::DIV_QW-1:0]    quo
);

  localparam int DW = ecr_pkg::DIV_DW;
  localparam int VW = ecr_pkg::DIV_VW;
  localparam int QW = ecr_pkg::DIV_QW;

  logic [VW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [VW-1:0] den_r [QW];

  logic [VW-1:0] rem_p [QW];
  logic [QW-1:0] low_p [QW];
  logic [VW-1:0] den_p [QW];

  // Upper dividend bits start below the divisor since the quotient fits QW bits.
  assign rem_p[0] = VW'(dvd[DW-1:QW]);
  assign low_p[0] = dvd[QW-1:0];
  assign den_p[0] = den;

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [VW:0]   t;
    logic          ge;
    logic [VW:0]   diff;

    if (k > 0) begin : g_link
      assign rem_p[k] = rem_r[k-1];
      assign low_p[k] = low_r[k-1];
      assign den_p[k] = den_r[k-1];
    end

    assign t    = {rem_p[k], low_p[k][QW-1]};
    assign diff = t - {1'b0, den_p[k]};
    assign ge   = (t >= {1'b0, den_p[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[VW-1:0] : t[VW-1:0];
        low_r[k] <= {low_p[k][QW-2:0], ge};
        den_r[k] <= den_p[k];
      end
    end
  end

  assign quo = low_r[QW-1];

endmodule

`default_nettype wire

// ===== src/ecr_back.sv =====
// ----------------------------------------------------------------------------
// ecr_back
// Mass weighting, rounding, velocity update and saturation (four stages).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecr_back (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ecr_pkg::DIV_QW-1:0] qx,
  input  wire logic [ecr_pkg::DIV_QW-1:0] qy,
  input  wire logic [ecr_pkg::DIV_QW-1:0] qw,
  input  wire ecr_pkg::sb_t               sb_in,
  output ecr_pkg::out_item_t              out_item
);

  localparam logic [65:0] RND = 66'd1 << 29;

  logic [33:0] pxm1_r, pym1_r;
  logic [31:0] w1_1_r, w2_1_r;
  ecr_pkg::sb_t sb1_r, sb2_r, sb3_r;
  logic [31:0] w2_sel;

  logic [48:0] x1h_r, x1l_r, y1h_r, y1l_r, x2h_r, x2l_r, y2h_r, y2l_r;
  logic [35:0] d1x_r, d1y_r, d2x_r, d2y_r;
  ecr_pkg::out_item_t out_r;

  function automatic logic [35:0] rnd_mag(input logic [48:0] hi, input logic [48:0] lo);
    logic [65:0] full;
    full = {hi, 17'b0} + 66'(lo) + RND;
    return full[65:30];
  endfunction

  function automatic logic signed [31:0] upd(input logic signed [31:0] v,
                                             input logic [35:0] d,
                                             input logic neg_d);
    logic signed [37:0] sd;
    sd = neg_d ? -$signed({2'b0, d}) : $signed({2'b0, d});
    return ecr_pkg::sat32(38'(v) + sd);
  endfunction

  assign w2_sel = sb_in.sum0 ? ecr_pkg::W_ONE : qw[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      // weights
      pxm1_r <= qx;
      pym1_r <= qy;
      w2_1_r <= w2_sel;
      w1_1_r <= ecr_pkg::W_TWO - w2_sel;
      sb1_r  <= sb_in;

      // split products
      x1h_r <= 49'(pxm1_r[33:17]) * 49'(w2_1_r);
      x1l_r <= 49'(pxm1_r[16:0])  * 49'(w2_1_r);
      y1h_r <= 49'(pym1_r[33:17]) * 49'(w2_1_r);
      y1l_r <= 49'(pym1_r[16:0])  * 49'(w2_1_r);
      x2h_r <= 49'(pxm1_r[33:17]) * 49'(w1_1_r);
      x2l_r <= 49'(pxm1_r[16:0])  * 49'(w1_1_r);
      y2h_r <= 49'(pym1_r[33:17]) * 49'(w1_1_r);
      y2l_r <= 49'(pym1_r[16:0])  * 49'(w1_1_r);
      sb2_r <= sb1_r;

      // rounded delta magnitudes
      d1x_r <= rnd_mag(x1h_r, x1l_r);
      d1y_r <= rnd_mag(y1h_r, y1l_r);
      d2x_r <= rnd_mag(x2h_r, x2l_r);
      d2y_r <= rnd_mag(y2h_r, y2l_r);
      sb3_r <= sb2_r;

      // update, pass through on coincident positions
      out_r.coincident <= sb3_r.coinc;
      if (sb3_r.coinc) begin
        out_r.first_new_vel_x  <= sb3_r.v1x;
        out_r.first_new_vel_y  <= sb3_r.v1y;
        out_r.second_new_vel_x <= sb3_r.v2x;
        out_r.second_new_vel_y <= sb3_r.v2y;
      end else begin
        out_r.first_new_vel_x  <= upd(sb3_r.v1x, d1x_r, sb3_r.spx);
        out_r.first_new_vel_y  <= upd(sb3_r.v1y, d1y_r, sb3_r.spy);
        out_r.second_new_vel_x <= upd(sb3_r.v2x, d2x_r, !sb3_r.spx);
        out_r.second_new_vel_y <= upd(sb3_r.v2y, d2y_r, !sb3_r.spy);
      end
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// ===== src/elastic_collision_response_2d.sv =====
// ----------------------------------------------------------------------------
// elastic_collision_response_2d
// Velocities of two discs after an elastic collision along their center axis.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  input   | in_valid, in_stall, in_data    | ecr_pkg::in_item_t (two discs)
//  result  | out_valid, out_stall, out_data | ecr_pkg::out_item_t (new velocities)
//
//  One pair enters per cycle unless stalled; each result passes in order through
//  9 front stages, 34 divider stages at one quotient bit each and 4 back stages.
//  Throughput is one pair per cycle unless stalled; the divider dominates latency.
//  Reset clears only the stage valid bits; no clearing pass is needed.
//  A stalled result freezes the whole pipe, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module elastic_collision_response_2d (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ecr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ecr_pkg::out_item_t      out_data
);

  localparam int FRONT_STAGES = 9;
  localparam int BACK_STAGES  = 4;
  localparam int QW           = ecr_pkg::DIV_QW;
  localparam int DEPTH        = FRONT_STAGES + QW + BACK_STAGES;

  logic             adv;
  logic [DEPTH-1:0] vld_r;

  logic [63:0]      fr_px_dvd, fr_py_dvd;
  logic [30:0]      fr_n;
  ecr_pkg::wt_t     fr_wt;
  ecr_pkg::sb_t     fr_sb;
  logic [QW-1:0]    qx, qy, qw;
  ecr_pkg::sb_t     sb_line_r [QW];

  // Advance everything unless a finished result is held by the consumer.
  assign adv       = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[DEPTH-1];

  // Stage valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  ecr_front u_front (
    .clk     (clk),
    .en      (adv),
    .in_item (in_data),
    .px_dvd  (fr_px_dvd),
    .py_dvd  (fr_py_dvd),
    .n_out   (fr_n),
    .wt_out  (fr_wt),
    .sb_out  (fr_sb)
  );

  // Projection components and the mass weight divide side by side.
  ecr_div u_div_px (
    .clk (clk),
    .en  (adv),
    .dvd (fr_px_dvd),
    .den ({2'b0, fr_n}),
    .quo (qx)
  );

  ecr_div u_div_py (
    .clk (clk),
    .en  (adv),
    .dvd (fr_py_dvd),
    .den ({2'b0, fr_n}),
    .quo (qy)
  );

  ecr_div u_div_w (
    .clk (clk),
    .en  (adv),
    .dvd (fr_wt.dvd),
    .den (fr_wt.den),
    .quo (qw)
  );

  // Delay the velocities and flags to match the divider depth.
  always_ff @(posedge clk) begin
    if (adv) begin
      sb_line_r[0] <= fr_sb;
      for (int i = 1; i < QW; i++) begin
        sb_line_r[i] <= sb_line_r[i-1];
      end
    end
  end

  ecr_back u_back (
    .clk      (clk),
    .en       (adv),
    .qx       (qx),
    .qy       (qy),
    .qw       (qw),
    .sb_in    (sb_line_r[QW-1]),
    .out_item (out_data)
  );

  `ECR_ASSERT_NXT(a_hold_frozen, out_valid && out_stall, $stable(vld_r), "pipe moved while held")
  `ECR_ASSERT_NXT(a_enter, in_valid && !in_stall, vld_r[0], "accepted pair not tracked")
  `ECR_ASSERT_IMP(a_out_origin, $rose(out_valid), $past(vld_r[DEPTH-2]), "result from nowhere")

endmodule

`default_nettype wire
